[rtl/core/sram_pkg.sv]
// Package for the sensor running-average monitor: shared types, constants and codes.
// Used by every module in rtl/core; it depends on nothing else.
package sram_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned WindowDefault  = 5;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [1:0] {
    ActLoad   = 2'd0,
    ActSample = 2'd1,
    ActQuery  = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    AlarmNone = 2'd0,
    AlarmHot  = 2'd1,
    AlarmCold = 2'd2
  } alarm_e;

  typedef enum logic [0:0] {
    StatusOk      = 1'b0,
    StatusUnknown = 1'b1
  } status_e;

  typedef enum logic [0:0] {
    CfgMaxTemp = 1'b0,
    CfgMinTemp = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         entry_index;
    logic [15:0]        probe_id;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_time;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        room_out;
    logic signed [15:0] average;
    logic [1:0]         alarm;
    logic [31:0]        last_time;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StDivide,
    StFinish,
    StOutput
  } exec_state_e;

endpackage

[rtl/core/sram_queue.sv]
// Short request queue between the front and the back part of the monitor.
// Depends on sram_pkg for the request type and the queue depth.
module sram_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sram_pkg::req_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output sram_pkg::req_t data_o,
  output logic          empty_o
);
  import sram_pkg::*;

  req_t       mem_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QueueDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

[rtl/core/sram_exec.sv]
// Back part of the monitor: table search, statistics update, divider and result register.
// Depends on sram_pkg for request, result and state types.
module sram_exec #(
  parameter int unsigned Entries = sram_pkg::EntriesDefault,
  parameter int unsigned Window  = sram_pkg::WindowDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sram_pkg::req_t     req_i,
  input  logic               req_empty_i,
  output logic               req_pop_o,
  input  logic signed [15:0] max_temp_i,
  input  logic signed [15:0] min_temp_i,
  output sram_pkg::rsp_t     rsp_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import sram_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = (Entries > 1) ? $clog2(Entries + 1) : 1;

  logic [Entries-1:0]  valid_q;
  logic [15:0]         sensor_q [Entries];
  logic [15:0]         room_q   [Entries];
  logic [2:0]          count_q  [Entries];
  logic signed [19:0]  sum_q    [Entries];
  logic signed [15:0]  avg_q    [Entries];
  logic [31:0]         time_q   [Entries];

  exec_state_e         state_q, state_d;
  req_t                cur_q;
  logic [CntW-1:0]     scan_q;
  logic [IdxW-1:0]     slot_q;
  rsp_t                out_q;
  logic                full_out_q;

  logic [19:0]         rem_q;
  logic [19:0]         quo_q;
  logic [2:0]          div_q;
  logic                neg_q;
  logic [4:0]          step_q;
  logic                win_q;
  logic signed [19:0]  newsum_q;

  logic [IdxW-1:0]     scan_idx;
  logic                hit;
  logic [20:0]         trial;
  logic signed [19:0]  quo_s;
  logic signed [15:0]  avg_new;
  logic [1:0]          alarm;
  rsp_t                search_rsp;
  rsp_t                finish_rsp;

  assign scan_idx  = scan_q[IdxW-1:0];
  assign hit       = valid_q[scan_idx] && (sensor_q[scan_idx] == cur_q.probe_id);
  assign trial     = {rem_q, quo_q[19]} - {18'd0, div_q};
  assign quo_s     = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign avg_new   = win_q ? 16'(avg_q[slot_q] + quo_s) : quo_s[15:0];
  assign rsp_o     = out_q;
  assign empty_o   = !full_out_q;
  assign req_pop_o = (state_q == StIdle) && !req_empty_i && !full_out_q;

  always_comb begin
    alarm = AlarmNone;
    if (win_q) begin
      if (avg_new > max_temp_i)      alarm = AlarmHot;
      else if (avg_new < min_temp_i) alarm = AlarmCold;
    end
  end

  always_comb begin
    search_rsp = '0;
    if (cur_q.action == ActLoad) begin
      search_rsp.room_out = cur_q.room_id;
    end else if (cur_q.action != ActNone) begin
      if (hit) begin
        search_rsp.room_out  = room_q[scan_idx];
        search_rsp.last_time = time_q[scan_idx];
        if (cur_q.action == ActQuery && count_q[scan_idx] >= 3'(Window)) begin
          search_rsp.average = avg_q[scan_idx];
        end
      end else if (scan_q == CntW'(Entries - 1)) begin
        search_rsp.status = StatusUnknown;
      end
    end
  end

  always_comb begin
    finish_rsp           = out_q;
    finish_rsp.average   = avg_new;
    finish_rsp.alarm     = alarm;
    finish_rsp.last_time = cur_q.sample_time;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (req_pop_o) state_d = StSearch;
      StSearch: if (cur_q.action == ActLoad || cur_q.action == ActNone || hit ||
                    scan_q == CntW'(Entries - 1)) begin
        state_d = (hit && cur_q.action == ActSample) ? StDivide : StOutput;
      end
      StDivide: if (step_q == 5'd19) state_d = StFinish;
      StFinish: state_d = StOutput;
      StOutput: if (!full_out_q) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      valid_q    <= '0;
      full_out_q <= 1'b0;
      for (int i = 0; i < Entries; i++) begin
        count_q[i] <= 3'd0;
        sum_q[i]   <= '0;
        avg_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop_i && full_out_q) full_out_q <= 1'b0;
      if (state_q == StOutput && !full_out_q) full_out_q <= 1'b1;
      if (state_q == StSearch && cur_q.action == ActLoad &&
          32'(cur_q.entry_index) < Entries) begin
        valid_q[IdxW'(cur_q.entry_index)] <= 1'b1;
        count_q[IdxW'(cur_q.entry_index)] <= 3'd0;
        sum_q[IdxW'(cur_q.entry_index)]   <= '0;
        avg_q[IdxW'(cur_q.entry_index)]   <= '0;
      end
      if (state_q == StFinish) begin
        avg_q[slot_q] <= avg_new;
        if (!win_q) begin
          count_q[slot_q] <= count_q[slot_q] + 3'd1;
          sum_q[slot_q]   <= newsum_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      cur_q  <= req_i;
      scan_q <= '0;
    end
    if (state_q == StSearch) begin
      scan_q <= scan_q + CntW'(1);
      slot_q <= scan_idx;
      out_q  <= search_rsp;
      if (cur_q.action == ActLoad && 32'(cur_q.entry_index) < Entries) begin
        sensor_q[IdxW'(cur_q.entry_index)] <= cur_q.probe_id;
        room_q[IdxW'(cur_q.entry_index)]   <= cur_q.room_id;
        time_q[IdxW'(cur_q.entry_index)]   <= '0;
      end
      if (hit && cur_q.action == ActSample) begin
        win_q  <= (count_q[scan_idx] >= 3'(Window));
        step_q <= '0;
        rem_q  <= '0;
        if (count_q[scan_idx] >= 3'(Window)) begin
          neg_q  <= (cur_q.sample_value < avg_q[scan_idx]);
          quo_q  <= (cur_q.sample_value < avg_q[scan_idx]) ?
                    20'(avg_q[scan_idx] - cur_q.sample_value) :
                    20'(cur_q.sample_value - avg_q[scan_idx]);
          div_q  <= 3'(Window);
        end else begin
          newsum_q <= sum_q[scan_idx] + 20'(cur_q.sample_value);
          neg_q    <= (sum_q[scan_idx] + 20'(cur_q.sample_value)) < 0;
          quo_q    <= ((sum_q[scan_idx] + 20'(cur_q.sample_value)) < 0) ?
                      20'(-(sum_q[scan_idx] + 20'(cur_q.sample_value))) :
                      20'(sum_q[scan_idx] + 20'(cur_q.sample_value));
          div_q    <= count_q[scan_idx] + 3'd1;
        end
      end
    end
    if (state_q == StDivide) begin
      step_q <= step_q + 5'd1;
      if (!trial[20]) begin
        rem_q <= trial[19:0];
        quo_q <= {quo_q[18:0], 1'b1};
      end else begin
        rem_q <= {rem_q[18:0], quo_q[19]};
        quo_q <= {quo_q[18:0], 1'b0};
      end
    end
    if (state_q == StFinish) begin
      time_q[slot_q] <= cur_q.sample_time;
      out_q          <= finish_rsp;
    end
  end
endmodule

[rtl/core/sensor_running_average_monitor_core.sv]
// Sensor running-average monitor, top level: request queue front, execution back, config.
// Loads and queries take the table search only; a sample also runs the divider.
// Throughput: one request at a time in the back part, which starts the next one only once
// the previous result has been taken; the table scan and the 20-step divider set its duration.
// Reset clears the table valid bits, statistics, queues and sets the thresholds to their extremes.
module sensor_running_average_monitor_core #(
  parameter int unsigned Entries = sram_pkg::EntriesDefault,
  parameter int unsigned Window  = sram_pkg::WindowDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  sram_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output sram_pkg::rsp_t rsp_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index_i,
  input  logic [15:0]    cfg_data_i
);
  import sram_pkg::*;

  logic signed [15:0] max_temp_q, min_temp_q;
  req_t               q_data;
  logic               q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_temp_q <= 16'sh7fff;
      min_temp_q <= 16'sh8000;
    end else if (cfg_valid) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgMaxTemp: max_temp_q <= cfg_data_i;
        CfgMinTemp: min_temp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sram_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(req_i), .full_o(full),
    .pop_i(q_pop), .data_o(q_data), .empty_o(q_empty)
  );

  sram_exec #(.Entries(Entries), .Window(Window)) u_exec (
    .clk_i, .rst_ni, .req_i(q_data), .req_empty_i(q_empty), .req_pop_o(q_pop),
    .max_temp_i(max_temp_q), .min_temp_i(min_temp_q),
    .rsp_o, .empty_o(empty), .pop_i(pop)
  );
endmodule

[test/sensor_running_average_monitor_core_checker.sv]
`timescale 1ns / 1ps
// Checker for the sensor running-average monitor: watches the request, response and
// config channels, predicts every response and compares it. Depends on sram_pkg.
module sensor_running_average_monitor_core_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic           full,
  input  sram_pkg::req_t req_i,
  input  logic           empty,
  input  logic           pop,
  input  sram_pkg::rsp_t rsp_o,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import sram_pkg::*;

  localparam int NumSlots = EntriesDefault;
  localparam int WinLen   = WindowDefault;

  logic signed [15:0] hot_limit, cold_limit;
  logic               slot_used [NumSlots];
  logic [15:0]        slot_sensor [NumSlots];
  logic [15:0]        slot_room [NumSlots];
  int                 slot_count [NumSlots];
  int                 slot_sum [NumSlots];
  int                 slot_avg [NumSlots];
  logic [31:0]        slot_time [NumSlots];
  rsp_t               awaited_rsp [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = awaited_rsp.size();

  function automatic rsp_t monitor_step(req_t r);
    rsp_t o;
    int   s;
    int   v;
    o = '0;
    s = -1;
    v = r.sample_value;
    if (r.action == ActLoad) begin
      slot_used[r.entry_index]   = 1'b1;
      slot_sensor[r.entry_index] = r.probe_id;
      slot_room[r.entry_index]   = r.room_id;
      slot_count[r.entry_index]  = 0;
      slot_sum[r.entry_index]    = 0;
      slot_avg[r.entry_index]    = 0;
      slot_time[r.entry_index]   = '0;
      o.room_out = r.room_id;
      return o;
    end
    if (r.action == ActNone) return o;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_sensor[i] == r.probe_id) s = i;
    end
    if (s < 0) begin
      o.status = StatusUnknown;
      return o;
    end
    o.room_out = slot_room[s];
    if (r.action == ActSample) begin
      slot_time[s] = r.sample_time;
      if (slot_count[s] >= WinLen) begin
        slot_avg[s] = slot_avg[s] + (v - slot_avg[s]) / WinLen;
        if (slot_avg[s] > int'(hot_limit)) o.alarm = AlarmHot;
        else if (slot_avg[s] < int'(cold_limit)) o.alarm = AlarmCold;
      end else begin
        slot_count[s] = slot_count[s] + 1;
        slot_sum[s]   = slot_sum[s] + v;
        slot_avg[s]   = slot_sum[s] / slot_count[s];
      end
      o.average = slot_avg[s][15:0];
    end else begin
      o.average = (slot_count[s] >= WinLen) ? slot_avg[s][15:0] : 16'sd0;
    end
    o.last_time = slot_time[s];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_limit  <= 16'sh7fff;
      cold_limit <= 16'sh8000;
      fails      <= 0;
      awaited_rsp.delete();
      for (int i = 0; i < NumSlots; i++) begin
        slot_used[i]  <= 1'b0;
        slot_count[i] <= 0;
        slot_sum[i]   <= 0;
        slot_avg[i]   <= 0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == CfgMaxTemp) hot_limit <= cfg_data_i;
        else cold_limit <= cfg_data_i;
      end
      if (pop && !empty) begin
        if (awaited_rsp.size() == 0) begin
          if (fails < 10) $display("unexpected response %h", rsp_o);
          fails <= fails + 1;
        end else begin
          rsp_t e;
          e = awaited_rsp.pop_front();
          if (e.status !== rsp_o.status || e.room_out !== rsp_o.room_out ||
              e.average !== rsp_o.average || e.alarm !== rsp_o.alarm ||
              e.last_time !== rsp_o.last_time) begin
            if (fails < 10)
              $display({"response differs: expected st %0d room %h avg %h alarm %0d t %h,",
                        " got st %0d room %h avg %h alarm %0d t %h"},
                       e.status, e.room_out, e.average, e.alarm, e.last_time,
                       rsp_o.status, rsp_o.room_out, rsp_o.average, rsp_o.alarm,
                       rsp_o.last_time);
            fails <= fails + 1;
          end
        end
      end
      if (push && !full) awaited_rsp.push_back(monitor_step(req_i));
    end
  end

endmodule

[test/sensor_running_average_monitor_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the sensor running-average monitor: drives requests, pops and
// threshold writes, and gives the verdict. Depends on sram_pkg, the core and the checker module.
module sensor_running_average_monitor_core_tb;
  import sram_pkg::*;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  req_t        req_i;
  rsp_t        rsp_o;
  logic        cfg_valid, cfg_ready, cfg_index_i;
  logic [15:0] cfg_data_i;
  int          fail_count, pending;
  int          idle_cycles;
  logic        quiet;
  int          pop_hold;

  logic        slot_used [16];
  logic [15:0] slot_sensor [16];
  logic        slot_sampled [16];
  logic [15:0] id_pool [8];

  sensor_running_average_monitor_core dut (.*);

  sensor_running_average_monitor_core_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .rsp_o, .cfg_valid,
    .cfg_ready, .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("sensor_running_average_monitor_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    pop = 1'b0;
    pop_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) pop_hold = $urandom_range(1, 5);
      end
    end
  end

  function automatic int lowest_slot(logic [15:0] id);
    for (int i = 0; i < 16; i++) if (slot_used[i] && slot_sensor[i] == id) return i;
    return -1;
  endfunction

  task automatic send(req_t r);
    int s;
    s = lowest_slot(r.probe_id);
    if (r.action == ActQuery && s >= 0 && !slot_sampled[s]) r.action = ActSample;
    if (r.action == ActLoad) begin
      slot_used[r.entry_index]    = 1'b1;
      slot_sensor[r.entry_index]  = r.probe_id;
      slot_sampled[r.entry_index] = 1'b0;
    end else if (r.action == ActSample && s >= 0) begin
      slot_sampled[s] = 1'b1;
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic make_req(logic [1:0] act, logic [3:0] idx, logic [15:0] sid,
                          logic [15:0] room, logic [15:0] val, logic [31:0] t);
    req_t r;
    r.action = act;
    r.entry_index = idx;
    r.probe_id = sid;
    r.room_id = room;
    r.sample_value = val;
    r.sample_time = t;
    send(r);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] value);
    push        <= 1'b0;
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_req();
    req_t        r;
    int          pick;
    logic [15:0] v;
    r = '0;
    r.entry_index = 4'($urandom_range(0, 15));
    r.room_id     = 16'($urandom);
    r.sample_time = $urandom;
    r.probe_id    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 19);
    if (pick < 3) r.action = ActLoad;
    else if (pick < 15) r.action = ActSample;
    else if (pick < 19) r.action = ActQuery;
    else r.action = ActNone;
    case ($urandom_range(0, 5))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 2000)) - 16'd1000;
      default: v = 16'($urandom);
    endcase
    r.sample_value = v;
    send(r);
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    req_i       = '0;
    cfg_valid   = 1'b0;
    cfg_index_i = CfgMaxTemp;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    for (int i = 0; i < 16; i++) begin
      slot_used[i] = 1'b0;
      slot_sampled[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hffff;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_cfg(CfgMaxTemp, 16'h7fff);
    write_cfg(CfgMinTemp, 16'h8000);
    make_req(ActSample, 4'd0, 16'h1234, 16'h0, 16'h0100, 32'h1);
    make_req(ActQuery, 4'd0, 16'h1234, 16'h0, 16'h0, 32'h0);
    make_req(ActLoad, 4'd0, 16'hffff, 16'hffff, 16'h0, 32'h0);
    make_req(ActLoad, 4'd15, 16'h0000, 16'h0000, 16'h0, 32'h0);
    make_req(ActLoad, 4'd7, 16'hffff, 16'h5a5a, 16'h0, 32'h0);
    for (int i = 0; i < 7; i++)
      make_req(ActSample, 4'd0, 16'hffff, 16'h0, 16'h7fff, 32'hffffffff);
    make_req(ActQuery, 4'd0, 16'hffff, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i < 7; i++)
      make_req(ActSample, 4'd0, 16'h0000, 16'h0, 16'h8000, 32'h0);
    make_req(ActQuery, 4'd0, 16'h0000, 16'h0, 16'h0, 32'h0);
    make_req(ActQuery, 4'd0, 16'hbeef, 16'h0, 16'h0, 32'h0);
    make_req(ActNone, 4'hf, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff);
    make_req(ActLoad, 4'd0, 16'hffff, 16'h1111, 16'h0, 32'h0);
    make_req(ActSample, 4'd0, 16'hffff, 16'h0, 16'hff00, 32'h10);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin write_cfg(CfgMaxTemp, 16'h0000); write_cfg(CfgMinTemp, 16'h0000); end
        1: begin write_cfg(CfgMaxTemp, 16'h8000); write_cfg(CfgMinTemp, 16'h7fff); end
        2: begin write_cfg(CfgMaxTemp, 16'h0400); write_cfg(CfgMinTemp, 16'hfc00); end
        default: begin
          write_cfg(CfgMaxTemp, 16'($urandom));
          write_cfg(CfgMinTemp, 16'($urandom));
        end
      endcase
      if (phase == 4) quiet = 1'b1;
      for (int n = 0; n < 130; n++) random_req();
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sensor_running_average_monitor_core: match");
    end else begin
      $display("sensor_running_average_monitor_core: mismatch");
    end
    $finish;
  end

endmodule
